// ----- src/rdstxt_pkg.sv -----
// Shared types, constants and helpers for the RDS group text assembler.
package rdstxt_pkg;

    // Stream widths
    localparam int IN_W  = 64;                 // four 16-bit blocks
    localparam int OUT_W = 24;                 // position, character, PTY, padding

    // Text stores
    localparam int RT_DEPTH           = 64;    // radio-text characters, 16 x 4
    localparam int RT_AW              = 6;
    localparam int PS_LEN             = 8;     // program service name characters
    localparam int RADIO_TEXT_LEN_DEF = 64;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [1:0] AB_NONE    = 2'd3;

    // Program service name after a clear: empty string padded with spaces
    localparam logic [7:0] PS_INIT [PS_LEN] = '{CHAR_NUL, CHAR_SPACE, CHAR_SPACE,
        CHAR_SPACE, CHAR_SPACE, CHAR_SPACE, CHAR_SPACE, CHAR_SPACE};

    // Group type codes, block B bits 15..11
    localparam logic [4:0] GT_0A = 5'd0;
    localparam logic [4:0] GT_0B = 5'd1;
    localparam logic [4:0] GT_2A = 5'd4;
    localparam logic [4:0] GT_2B = 5'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_TERM,
        S_START,
        S_EMIT
    } t_state;

    // Command bundle from the sequencer to the radio-text store
    typedef struct packed {
        logic             clr_all;
        logic             clr_first;
        logic             wr_en;
        logic [RT_AW-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [RT_AW-1:0] rd_addr;
    } t_ram_cmd;

    // Control bytes show as space in radio text
    function automatic logic [7:0] printable(input logic [7:0] c);
        return (c < CHAR_SPACE) ? CHAR_SPACE : c;
    endfunction

endpackage

// ----- src/rdstxt_text_ram.sv -----
// Radio-text store: 64 x 8 synchronous RAM with per-entry valid bits.
module rdstxt_text_ram
    import rdstxt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ram_cmd   i_cmd,
    output logic [7:0] o_q
);

    logic [7:0]        mem [RT_DEPTH];
    logic [RT_DEPTH-1:0] r_valid;
    logic [7:0]        r_q;
    logic              r_q_valid;
    logic              r_q_first;

    // Array write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_q       <= mem[i_cmd.rd_addr];
            r_q_first <= (i_cmd.rd_addr == '0);
        end
    end

    // Valid bits: an entry never written since the last clear reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_q_valid <= r_valid[i_cmd.rd_addr];
            end
            if (i_cmd.clr_all) begin
                r_valid <= '0;
            end else begin
                if (i_cmd.clr_first) begin
                    r_valid[0] <= 1'b0;
                end
                if (i_cmd.wr_en) begin
                    r_valid[i_cmd.wr_addr] <= 1'b1;
                end
            end
        end
    end

    // Entry zero resets to NUL, all others to space
    assign o_q = r_q_valid ? r_q : (r_q_first ? CHAR_NUL : CHAR_SPACE);

endmodule

// ----- src/rds_group_text_assembler.sv -----
// Top level: RDS group decoder assembling PS name and radio text into character runs.
// Sequence: a segment-0 0A/0B group goes through S_START to S_EMIT; a radio-text group writes
// its characters in S_WRITE, and a segment 0 that closes a line adds S_TERM, S_START and S_EMIT.
// Throughput: one character per cycle out of the store read port while the output is not
// stalled; the input is held (not ready) until the last beat of the run is in the output register.
// Reset (sync, active low) clears control state and the valid bits of the text RAM,
// so the whole store reads as its reset text at once: no clearing pass.
module rds_group_text_assembler
    import rdstxt_pkg::*;
#(
    parameter int RADIO_TEXT_LEN = RADIO_TEXT_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // block_a, block_b, block_c, block_d
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // char_position, character, program_type
    output logic             o_m_axis_tlast,   // run_last
    output logic             o_m_axis_tuser    // text_kind
);

    localparam logic [6:0] RT_LIM = 7'(RADIO_TEXT_LEN);
    localparam logic [6:0] PS_LIM = 7'(PS_LEN);

    // Input fields
    logic [15:0] in_a, in_b, in_c, in_d;
    logic [4:0]  gtype;
    assign in_a  = i_s_axis_tdata[15:0];
    assign in_b  = i_s_axis_tdata[31:16];
    assign in_c  = i_s_axis_tdata[47:32];
    assign in_d  = i_s_axis_tdata[63:48];
    assign gtype = in_b[15:11];

    // State
    t_state      r_state, n_state;
    logic [15:0] r_last_station, n_last_station;
    logic        r_seen, n_seen;
    logic [1:0]  r_last_ab, n_last_ab;
    logic [5:0]  r_ext, n_ext;
    logic        r_ev, n_ev;
    logic [7:0]  r_ps [PS_LEN];
    logic [7:0]  n_ps [PS_LEN];
    logic [7:0]  r_ps_q;

    // Write sequencer
    logic [7:0]  r_wc [4];
    logic [7:0]  n_wc [4];
    logic [5:0]  r_wadr, n_wadr;
    logic [1:0]  r_wcnt, n_wcnt;
    logic [1:0]  r_wlast, n_wlast;
    logic        r_term, n_term;
    logic [6:0]  r_term_idx, n_term_idx;

    // Emission
    logic        r_kind, n_kind;
    logic [4:0]  r_pty, n_pty;
    logic [6:0]  r_nxt, n_nxt;
    logic        r_qv, n_qv;
    logic        r_hv, n_hv;
    logic [7:0]  r_hc, n_hc;
    logic [5:0]  r_hi, n_hi;

    // Output register
    logic        r_o_valid, n_o_valid;
    logic [5:0]  r_o_pos, n_o_pos;
    logic [7:0]  r_o_char, n_o_char;
    logic        r_o_last, n_o_last;
    logic        r_o_kind, n_o_kind;
    logic [4:0]  r_o_pty, n_o_pty;

    // Combinational helpers
    t_ram_cmd    ram_cmd;
    logic [7:0]  ram_q;
    logic [7:0]  qb;
    logic [6:0]  lim;
    logic [6:0]  nxt_inc;
    logic        slot_free;
    logic        run_end;
    logic        rd_issue;
    logic [6:0]  rd_idx;
    logic        clr;
    logic [1:0]  ab_eff;
    logic        ev_eff;
    logic [5:0]  ext_eff;
    logic [2:0]  ps_adr;
    logic [5:0]  last_idx;

    rdstxt_text_ram u_text_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ram_cmd),
        .o_q     (ram_q)
    );

    assign qb        = r_kind ? r_ps_q : ram_q;
    assign lim       = r_kind ? PS_LIM : RT_LIM;
    assign nxt_inc   = r_nxt + 7'd1;
    assign slot_free = !r_o_valid || i_m_axis_tready;
    assign run_end   = (r_nxt == lim) || (r_qv && (qb == CHAR_NUL));

    // Next state and datapath
    always_comb begin
        n_state        = r_state;
        n_last_station = r_last_station;
        n_seen         = r_seen;
        n_last_ab      = r_last_ab;
        n_ext          = r_ext;
        n_ev           = r_ev;
        n_ps           = r_ps;
        n_wc           = r_wc;
        n_wadr         = r_wadr;
        n_wcnt         = r_wcnt;
        n_wlast        = r_wlast;
        n_term         = r_term;
        n_term_idx     = r_term_idx;
        n_kind         = r_kind;
        n_pty          = r_pty;
        n_nxt          = r_nxt;
        n_qv           = r_qv;
        n_hv           = r_hv;
        n_hc           = r_hc;
        n_hi           = r_hi;
        n_o_valid      = r_o_valid && !i_m_axis_tready;
        n_o_pos        = r_o_pos;
        n_o_char       = r_o_char;
        n_o_last       = r_o_last;
        n_o_kind       = r_o_kind;
        n_o_pty        = r_o_pty;
        ram_cmd        = '0;
        rd_issue       = 1'b0;
        rd_idx         = '0;
        clr            = 1'b0;
        ab_eff         = r_last_ab;
        ev_eff         = r_ev;
        ext_eff        = r_ext;
        ps_adr         = '0;
        last_idx       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    // New station clears all text before this group is decoded
                    clr = (in_a != 16'd0) && (!r_seen || (in_a != r_last_station));
                    if (clr) begin
                        n_last_station  = in_a;
                        n_seen          = 1'b1;
                        ram_cmd.clr_all = 1'b1;
                        ab_eff          = AB_NONE;
                        ev_eff          = 1'b0;
                        ext_eff         = '0;
                        n_ps            = PS_INIT;
                    end
                    n_last_ab = ab_eff;
                    n_ev      = ev_eff;
                    n_ext     = ext_eff;
                    n_pty     = in_b[9:5];

                    case (gtype)
                        GT_0A, GT_0B: begin
                            // Two PS characters, name goes out at segment 0
                            ps_adr                = {in_b[1:0], 1'b0};
                            n_ps[ps_adr]          = in_d[15:8];
                            n_ps[ps_adr | 3'd1]   = in_d[7:0];
                            if (in_b[1:0] == 2'd0) begin
                                n_kind  = 1'b1;
                                n_state = S_START;
                            end
                        end
                        GT_2A, GT_2B: begin
                            // A/B flip drops the pending line
                            if ({1'b0, in_b[4]} != ab_eff) begin
                                n_last_ab         = {1'b0, in_b[4]};
                                ram_cmd.clr_first = 1'b1;
                                ev_eff            = 1'b0;
                            end
                            if (gtype == GT_2A) begin
                                n_wadr  = {in_b[3:0], 2'b00};
                                n_wc[0] = printable(in_c[15:8]);
                                n_wc[1] = printable(in_c[7:0]);
                                n_wc[2] = printable(in_d[15:8]);
                                n_wc[3] = printable(in_d[7:0]);
                                n_wlast = 2'd3;
                            end else begin
                                n_wadr  = {1'b0, in_b[3:0], 1'b0};
                                n_wc[0] = printable(in_d[15:8]);
                                n_wc[1] = printable(in_d[7:0]);
                                n_wc[2] = CHAR_SPACE;
                                n_wc[3] = CHAR_SPACE;
                                n_wlast = 2'd1;
                            end
                            last_idx = n_wadr + {4'd0, n_wlast};
                            // Segment 0 closes the previous line, others track its extent
                            if (n_wadr == 6'd0) begin
                                n_term     = ev_eff && (ext_eff != 6'd0);
                                n_term_idx = {1'b0, ext_eff} + 7'd1;
                                n_ext      = '0;
                                n_ev       = 1'b1;
                            end else begin
                                n_term = 1'b0;
                                n_ev   = ev_eff;
                                if (ev_eff && (n_wadr > ext_eff)) begin
                                    n_ext = last_idx;
                                end
                            end
                            n_kind  = 1'b0;
                            n_wcnt  = '0;
                            n_state = S_WRITE;
                        end
                        default: ;
                    endcase
                end
            end

            S_WRITE: begin
                // One character per cycle into the RAM
                ram_cmd.wr_en   = 1'b1;
                ram_cmd.wr_addr = r_wadr + {4'd0, r_wcnt};
                ram_cmd.wr_data = r_wc[r_wcnt];
                n_wcnt          = r_wcnt + 2'd1;
                if (r_wcnt == r_wlast) begin
                    n_state = r_term ? S_TERM : S_IDLE;
                end
            end

            S_TERM: begin
                // Terminator after the line; past the end it is never read
                if (!r_term_idx[6]) begin
                    ram_cmd.wr_en   = 1'b1;
                    ram_cmd.wr_addr = r_term_idx[5:0];
                    ram_cmd.wr_data = CHAR_NUL;
                end
                n_state = S_START;
            end

            S_START: begin
                rd_issue = 1'b1;
                rd_idx   = '0;
                n_nxt    = '0;
                n_qv     = 1'b1;
                n_hv     = 1'b0;
                n_state  = S_EMIT;
            end

            S_EMIT: begin
                if (!r_hv) begin
                    // First character into the hold stage
                    n_hv = 1'b1;
                    n_hc = qb;
                    n_hi = r_nxt[5:0];
                    if (qb == CHAR_NUL) begin
                        n_nxt = lim;
                        n_qv  = 1'b0;
                    end else begin
                        n_nxt = nxt_inc;
                        if (nxt_inc < lim) begin
                            rd_issue = 1'b1;
                            rd_idx   = nxt_inc;
                            n_qv     = 1'b1;
                        end else begin
                            n_qv = 1'b0;
                        end
                    end
                end else if (slot_free && (run_end || r_qv)) begin
                    // Held character goes out; lookahead decides the last flag
                    n_o_valid = 1'b1;
                    n_o_pos   = r_hi;
                    n_o_char  = r_hc;
                    n_o_last  = run_end;
                    n_o_kind  = r_kind;
                    n_o_pty   = r_pty;
                    if (run_end) begin
                        n_hv    = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_hc  = qb;
                        n_hi  = r_nxt[5:0];
                        n_nxt = nxt_inc;
                        if (nxt_inc < lim) begin
                            rd_issue = 1'b1;
                            rd_idx   = nxt_inc;
                            n_qv     = 1'b1;
                        end else begin
                            n_qv = 1'b0;
                        end
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase

        ram_cmd.rd_en   = rd_issue;
        ram_cmd.rd_addr = rd_idx[5:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_last_station <= '0;
            r_seen         <= 1'b0;
            r_last_ab      <= AB_NONE;
            r_ext          <= '0;
            r_ev           <= 1'b0;
            r_ps           <= PS_INIT;
            r_qv           <= 1'b0;
            r_hv           <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_last_station <= n_last_station;
            r_seen         <= n_seen;
            r_last_ab      <= n_last_ab;
            r_ext          <= n_ext;
            r_ev           <= n_ev;
            r_ps           <= n_ps;
            r_qv           <= n_qv;
            r_hv           <= n_hv;
            r_o_valid      <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wc       <= n_wc;
        r_wadr     <= n_wadr;
        r_wcnt     <= n_wcnt;
        r_wlast    <= n_wlast;
        r_term     <= n_term;
        r_term_idx <= n_term_idx;
        r_kind     <= n_kind;
        r_pty      <= n_pty;
        r_nxt      <= n_nxt;
        r_hc       <= n_hc;
        r_hi       <= n_hi;
        r_o_pos    <= n_o_pos;
        r_o_char   <= n_o_char;
        r_o_last   <= n_o_last;
        r_o_kind   <= n_o_kind;
        r_o_pty    <= n_o_pty;
        if (rd_issue) begin
            r_ps_q <= r_ps[rd_idx[2:0]];
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {5'd0, r_o_pty, r_o_char, r_o_pos};
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_o_kind;

endmodule

// ----- src/rdstxt_checker.sv -----
// Port-level checks for the RDS group text assembler, bound to the top level.
module rdstxt_checker
    import rdstxt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic [IN_W-1:0]  i_s_axis_tdata,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast,
    input logic             o_m_axis_tuser
);

    // Output beat register comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat valid right after reset");

    // A stalled beat holds its contents
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("stalled output beat changed");

    // A NUL character only marks an empty string: position 0, last beat
    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[13:6] == 8'd0) |->
            o_m_axis_tlast && (o_m_axis_tdata[5:0] == 6'd0))
        else $error("NUL character inside a run");

    // Service name beats stay within the eight-character name
    a_ps_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> (o_m_axis_tdata[5:0] < 6'(PS_LEN)))
        else $error("service name position out of range");

    // Radio-text groups always spend cycles writing the store
    a_rt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready &&
            ((i_s_axis_tdata[31:27] == GT_2A) || (i_s_axis_tdata[31:27] == GT_2B))
            |=> !o_s_axis_tready)
        else $error("input ready right after a radio-text group");

endmodule

bind rds_group_text_assembler rdstxt_checker u_rdstxt_checker (.*);

// ----- tb/tb_rds_group_text_assembler.sv -----
// Self-checking testbench for rds_group_text_assembler: directed and random RDS groups.
`timescale 1ns / 100ps

module tb_rds_group_text_assembler;
    import rdstxt_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int N_TEXT_GROUPS = 400;
    localparam int STALL_LIMIT  = 2000;    // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 40;      // quiet time after the last expected beat
    localparam int LINE_MAX     = RADIO_TEXT_LEN_DEF;

    // One expected output beat
    typedef struct packed {
        logic       kind;      // 0 radio text, 1 service name
        logic [5:0] pos;
        logic [7:0] ch;
        logic       last;
        logic [4:0] pty;
    } t_char_beat;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_COMB,
        RX_SPARSE
    } t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata = '0;     // block_a, block_b, block_c, block_d
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_axis_tdata;          // char_position, character, program_type
    logic              o_m_axis_tlast;          // run_last
    logic              o_m_axis_tuser;          // text_kind

    // Shadow of the decoder state
    logic [7:0]  rt_text [0:64];
    logic [7:0]  ps_name [0:PS_LEN-1];
    logic [1:0]  ab_prev;
    logic [6:0]  rt_extent;
    logic        rt_extent_ok;
    logic [15:0] pi_last;
    logic        pi_known;

    t_char_beat  pending_chars [$];

    // Stimulus state
    int          burst_left = 0;
    logic [15:0] pi_cur = 16'h1234;
    logic        ab_cur = 1'b0;

    // Bookkeeping
    int groups_sent = 0;
    int text_groups = 0;
    int rt_runs = 0;
    int ps_runs = 0;
    int beats_checked = 0;
    int errors = 0;
    int idle_cycles = 0;

    t_rx_mode rx_mode = RX_STEADY;
    int       rx_mode_left = 0;
    int       rx_phase = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    rds_group_text_assembler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // ---------------------------------------------------------------- prediction

    function automatic void clear_text_state();
        for (int i = 0; i <= 64; i++) rt_text[i] = CHAR_SPACE;
        rt_text[0] = CHAR_NUL;
        for (int i = 0; i < PS_LEN; i++) ps_name[i] = CHAR_SPACE;
        ps_name[0] = CHAR_NUL;
        ab_prev = AB_NONE;
        rt_extent = '0;
        rt_extent_ok = 1'b0;
    endfunction

    // Radio text shows control bytes as space
    function automatic logic [7:0] rt_byte(input logic [7:0] c);
        return (c < 8'h20) ? CHAR_SPACE : c;
    endfunction

    function automatic logic [7:0] run_char(input logic kind, input int idx);
        return kind ? ps_name[idx] : rt_text[idx];
    endfunction

    // Queue one string as a run of beats, cut at the first zero byte
    function automatic void push_run(input logic kind, input logic [4:0] pty);
        int lim;
        int n;
        lim = kind ? PS_LEN : LINE_MAX;
        n = 0;
        while (n < lim && n < 64 && run_char(kind, n) != CHAR_NUL) n++;
        if (n == 0) begin
            pending_chars.push_back(t_char_beat'{kind, 6'd0, CHAR_NUL, 1'b1, pty});
        end else begin
            for (int k = 0; k < n; k++)
                pending_chars.push_back(t_char_beat'{kind, 6'(k), run_char(kind, k),
                                                     (k == n - 1), pty});
        end
        if (kind) ps_runs++;
        else rt_runs++;
    endfunction

    function automatic void predict_group(input logic [15:0] a, b, c, d);
        logic [4:0] gtype;
        logic [4:0] pty;
        logic [3:0] seg;
        logic       ab;
        int         adr;
        int         last_idx;
        gtype = b[15:11];
        pty   = b[9:5];
        seg   = b[3:0];
        ab    = b[4];

        // New station wipes the text
        if (a != 16'h0000 && (!pi_known || a != pi_last)) begin
            clear_text_state();
            pi_last = a;
            pi_known = 1'b1;
        end

        if (gtype == GT_0A || gtype == GT_0B) begin
            text_groups++;
            adr = int'(b[1:0]) * 2;
            ps_name[adr]     = d[15:8];
            ps_name[adr + 1] = d[7:0];
            if (adr == 0) push_run(1'b1, pty);
        end else if (gtype == GT_2A || gtype == GT_2B) begin
            text_groups++;
            if ({1'b0, ab} != ab_prev) begin
                ab_prev = {1'b0, ab};
                rt_text[0] = CHAR_NUL;
                rt_extent_ok = 1'b0;
            end
            if (gtype == GT_2A) begin
                adr = int'(seg) * 4;
                rt_text[adr]     = rt_byte(c[15:8]);
                rt_text[adr + 1] = rt_byte(c[7:0]);
                rt_text[adr + 2] = rt_byte(d[15:8]);
                rt_text[adr + 3] = rt_byte(d[7:0]);
                last_idx = adr + 3;
            end else begin
                adr = int'(seg) * 2;
                rt_text[adr]     = rt_byte(d[15:8]);
                rt_text[adr + 1] = rt_byte(d[7:0]);
                last_idx = adr + 1;
            end
            if (adr == 0) begin
                if (rt_extent_ok && rt_extent > 0) begin
                    rt_text[int'(rt_extent) + 1] = CHAR_NUL;
                    push_run(1'b0, pty);
                end
                rt_extent = '0;
                rt_extent_ok = 1'b1;
            end else if (rt_extent_ok && adr > int'(rt_extent)) begin
                rt_extent = 7'(last_idx & 8'h3F);
            end
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [15:0] group_b(input logic [4:0] gtype, input logic [4:0] pty,
                                            input logic ab, input logic [3:0] seg);
        return {gtype, 1'($urandom_range(0, 1)), pty, ab, seg};
    endfunction

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 31));       // control byte or zero
            1: return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    function automatic logic [15:0] rand_pair();
        return {rand_char(), rand_char()};
    endfunction

    // Mostly the current station, sometimes a zero PI
    function automatic logic [15:0] pick_pi();
        return ($urandom_range(0, 7) == 0) ? 16'h0000 : pi_cur;
    endfunction

    // Drive one group; sender runs in bursts separated by random gaps
    task automatic send_group(input logic [15:0] a, b, c, d);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end else begin
            @(negedge i_clk);
        end
        i_s_axis_tdata  <= {d, c, b, a};
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        burst_left--;
        groups_sent++;
        predict_group(a, b, c, d);
    endtask

    task automatic send_rt_group(input logic is_2a, input logic ab, input logic [3:0] seg,
                                 input logic [4:0] pty);
        send_group(pick_pi(), group_b(is_2a ? GT_2A : GT_2B, pty, ab, seg),
                   rand_pair(), rand_pair());
    endtask

    // ---------------------------------------------------------------- tests

    // Empty name, a full name built out of order, both 0A and 0B
    task automatic test_service_name();
        send_group(16'h0000, group_b(GT_0A, 5'd0, 1'b0, 4'h0), 16'h0000, 16'h0041);
        send_group(16'hFFFF, group_b(GT_0B, 5'd31, 1'b1, 4'h1), 16'h0000, 16'h5352);
        send_group(16'hFFFF, group_b(GT_0A, 5'd31, 1'b0, 4'hE), 16'hFFFF, 16'h4144);
        send_group(16'hFFFF, group_b(GT_0B, 5'd31, 1'b0, 4'h3), 16'h1234, 16'h494F);
        send_group(16'hFFFF, group_b(GT_0A, 5'd17, 1'b1, 4'hC), 16'h0000, 16'h5244);
    endtask

    // Lines from 2A and 2B groups, control bytes, high bytes, a shorter second line
    task automatic test_radio_text();
        send_group(16'hFFFF, group_b(GT_2A, 5'd5, 1'b0, 4'h0), 16'h011F, 16'h4142);
        send_group(16'hFFFF, group_b(GT_2A, 5'd5, 1'b0, 4'h1), 16'hFF20, 16'h7E80);
        send_group(16'hFFFF, group_b(GT_2A, 5'd5, 1'b0, 4'h2), 16'h4344, 16'h0A0D);
        send_group(16'hFFFF, group_b(GT_2B, 5'd9, 1'b0, 4'h0), 16'hFFFF, 16'h5A59);
        send_group(16'hFFFF, group_b(GT_2B, 5'd9, 1'b0, 4'h3), 16'h0000, 16'h3132);
        send_group(16'hFFFF, group_b(GT_2B, 5'd2, 1'b0, 4'h0), 16'h0000, 16'h0000);
    endtask

    // A/B flip drops the line, other group types, station change, zero PI
    task automatic test_ab_and_station();
        send_group(16'hFFFF, group_b(GT_2B, 5'd3, 1'b1, 4'h4), 16'h0000, 16'h4849);
        send_group(16'hFFFF, group_b(GT_2A, 5'd3, 1'b1, 4'h0), 16'h6162, 16'h6364);
        send_group(16'hFFFF, group_b(GT_2A, 5'd3, 1'b1, 4'h1), 16'h6566, 16'h6768);
        send_group(16'hFFFF, group_b(GT_2A, 5'd4, 1'b1, 4'h0), 16'h696A, 16'h6B6C);
        send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_group(16'h0001, group_b(GT_2A, 5'd6, 1'b1, 4'h1), 16'h5051, 16'h5253);
        send_group(16'h0000, group_b(GT_0A, 5'd7, 1'b0, 4'h0), 16'h0000, 16'hFFFF);
        send_group(16'h0000, group_b(GT_2B, 5'd8, 1'b0, 4'h0), 16'h0000, 16'h3031);
        send_group(16'h0000, group_b(GT_2B, 5'd8, 1'b0, 4'hF), 16'h0000, 16'h3839);
        send_group(16'h0000, group_b(GT_2B, 5'd8, 1'b0, 4'h0), 16'h0000, 16'h3233);
        send_group(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Mostly well-formed lines and names, plus noise and broken sequences
    task automatic test_random_groups();
        logic       is_2a;
        logic [4:0] pty;
        int         nseg;
        int         pick;
        while (text_groups < N_TEXT_GROUPS) begin
            pick = $urandom_range(0, 99);
            pty = 5'($urandom_range(0, 31));
            if (pick < 45) begin
                // radio-text line: open, fill, close
                if ($urandom_range(0, 5) == 0) ab_cur = ~ab_cur;
                is_2a = 1'($urandom_range(0, 1));
                nseg = ($urandom_range(0, 5) == 0) ? 15 : $urandom_range(1, 8);
                send_rt_group(is_2a, ab_cur, 4'h0, pty);
                for (int s = 1; s <= nseg; s++) begin
                    send_rt_group(($urandom_range(0, 9) == 0) ? ~is_2a : is_2a, ab_cur,
                                  ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15))
                                                              : 4'(s), pty);
                end
                send_rt_group(is_2a, ab_cur, 4'h0, pty);
            end else if (pick < 70) begin
                // service name: segments 1..3 in loose order, then segment 0
                for (int s = 1; s <= 3; s++) begin
                    send_group(pick_pi(),
                               group_b(($urandom_range(0, 1) == 1) ? GT_0B : GT_0A, pty,
                                       1'($urandom_range(0, 1)),
                                       {2'($urandom_range(0, 3)),
                                        ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                                                    : 2'(s)}),
                               16'($urandom), rand_pair());
                end
                send_group(pick_pi(), group_b(GT_0A, pty, 1'($urandom_range(0, 1)),
                                              {2'($urandom_range(0, 3)), 2'b00}),
                           16'($urandom), rand_pair());
            end else if (pick < 82) begin
                // raw noise: any group type, any PI
                repeat ($urandom_range(1, 3))
                    send_group(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick < 90) begin
                pi_cur = 16'($urandom_range(1, 65535));
            end else begin
                // broken line: random segments and flags
                repeat ($urandom_range(1, 6))
                    send_rt_group(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  4'($urandom_range(0, 15)), pty);
            end
        end
    endtask

    task automatic drain_outputs();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- receiver

    // Stall pattern switches between random modes: steady, coin toss, comb and sparse
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_STEADY: i_m_axis_tready <= 1'b1;
            RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_COMB:   i_m_axis_tready <= (rx_phase % 7) < 4;
            RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 5) == 0);
            default:   i_m_axis_tready <= 1'b1;
        endcase
    end

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin
        t_char_beat got;
        t_char_beat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tuser, o_m_axis_tdata[5:0], o_m_axis_tdata[13:6],
                   o_m_axis_tlast, o_m_axis_tdata[18:14]};
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual kind=%0d pos=%0d",
                         $time, got.kind, got.pos);
                $display("    char=%02h last=%0d pty=%0d", got.ch, got.last, got.pty);
            end else begin
                want = pending_chars.pop_front();
                beats_checked++;
                if (got.kind !== want.kind || got.pos !== want.pos || got.ch !== want.ch ||
                    got.last !== want.last || got.pty !== want.pty) begin
                    errors++;
                    $display("%0t: mismatch expected kind=%0d pos=%0d char=%02h last=%0d pty=%0d",
                             $time, want.kind, want.pos, want.ch, want.last, want.pty);
                    $display("    actual kind=%0d pos=%0d char=%02h last=%0d pty=%0d",
                             got.kind, got.pos, got.ch, got.last, got.pty);
                end
            end
        end
    end

    // Watchdog: no beat on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d beats still expected", $time, pending_chars.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main

    initial begin
        clear_text_state();
        pi_last = 16'h0000;
        pi_known = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_service_name();
        test_radio_text();
        test_ab_and_station();
        test_random_groups();
        drain_outputs();

        $display("Sent %0d groups (%0d text groups), %0d radio-text and %0d service-name runs",
                 groups_sent, text_groups, rt_runs, ps_runs);
        $display("Checked %0d character beats, %0d errors", beats_checked, errors);
        if (errors == 0 && pending_chars.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
